@@ hw/rtl/uera_pkg.sv @@
// Shared types, constants and register map of the averaging ultrasonic echo ranger.
package uera_pkg;

  // Default build parameters.
  localparam int SAMPLES_DEF    = 5;
  localparam int ECHO_WIDTH_DEF = 16;

  // Fixed field widths.
  localparam int TRIG_LEN_W = 10;
  localparam int GAP_W      = 16;
  localparam int DIST_W     = 15;
  localparam int DATA_W     = 32;
  localparam int ADDR_W     = 3;

  // Register reset values.
  localparam logic [TRIG_LEN_W-1:0] TRIG_LEN_RESET = 10'd20;
  localparam logic [GAP_W-1:0]      GAP_RESET      = 16'd10000;

  // Distance arithmetic: 58 us of echo per cm, four fraction bits.
  localparam int EchoUsPerCm = 58;
  localparam int QFrac       = 4;
  localparam logic [DIST_W-1:0] DIST_MAX = 15'h7fff;

  // Register indexes, taken from the word address bit.
  typedef enum logic {
    REG_TRIGGER_LEN = 1'b0,
    REG_GAP         = 1'b1
  } reg_idx_t;

  // Measurement sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_TRIG,
    PH_WAIT,
    PH_MEAS,
    PH_GAP
  } phase_t;

  // Configuration register values.
  typedef struct packed {
    logic [TRIG_LEN_W-1:0] trigger_len_us;
    logic [GAP_W-1:0]      gap_us;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic              trigger_level;
    logic              busy_res;
    logic              done_res;
    logic [DIST_W-1:0] distance_q4;
  } res_t;

endpackage

@@ hw/rtl/uera_in_if.sv @@
// Request channel carrying one microsecond tick with start request and echo level.
interface uera_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo_level;

  modport source (output valid, output start_req, output echo_level, input ready);
  modport sink (input valid, input start_req, input echo_level, output ready);
endinterface

@@ hw/rtl/uera_out_if.sv @@
// Result channel carrying trigger level, status and the averaged distance.
interface uera_out_if;
  logic                            valid;
  logic                            ready;
  logic                            trigger_level;
  logic                            busy_res;
  logic                            done_res;
  logic [uera_pkg::DIST_W-1:0]     distance_q4;

  modport source (
    output valid, output trigger_level, output busy_res, output done_res,
    output distance_q4, input ready
  );
  modport sink (
    input valid, input trigger_level, input busy_res, input done_res,
    input distance_q4, output ready
  );
endinterface

@@ hw/rtl/uera_regs.sv @@
// APB-style configuration registers: trigger length and inter-round gap.
module uera_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uera_pkg::ADDR_W-1:0]   paddr,
  input  logic [uera_pkg::DATA_W-1:0]   pwdata,
  output logic [uera_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output uera_pkg::cfg_t                cfg
);

  logic              wr_en;
  uera_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = uera_pkg::reg_idx_t'(paddr[uera_pkg::ADDR_W-1]);

  // Register writes on the access cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.trigger_len_us <= uera_pkg::TRIG_LEN_RESET;
      cfg.gap_us         <= uera_pkg::GAP_RESET;
    end else if (wr_en) begin
      unique case (idx)
        uera_pkg::REG_TRIGGER_LEN: begin
          cfg.trigger_len_us <= pwdata[uera_pkg::TRIG_LEN_W-1:0];
        end
        uera_pkg::REG_GAP: begin
          cfg.gap_us <= pwdata[uera_pkg::GAP_W-1:0];
        end
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (idx)
      uera_pkg::REG_TRIGGER_LEN: begin
        prdata = uera_pkg::DATA_W'(cfg.trigger_len_us);
      end
      uera_pkg::REG_GAP: begin
        prdata = uera_pkg::DATA_W'(cfg.gap_us);
      end
    endcase
  end

endmodule

@@ hw/rtl/uera_core.sv @@
// Measurement sequencer: trigger, echo timing, accumulation and averaged distance.
module uera_core #(
  parameter int SAMPLES         = uera_pkg::SAMPLES_DEF,
  parameter int ECHO_WIDTH_BITS = uera_pkg::ECHO_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           start_req,
  input  logic           echo_level,
  input  uera_pkg::cfg_t cfg,
  output uera_pkg::res_t res
);

  localparam int CNT_W   = (ECHO_WIDTH_BITS > uera_pkg::GAP_W) ? ECHO_WIDTH_BITS
                                                              : uera_pkg::GAP_W;
  localparam int RND_W   = $clog2(SAMPLES + 1);
  localparam int SUM_W   = $clog2(SAMPLES * ((1 << ECHO_WIDTH_BITS) - 1) + 1);
  // Divide sum * 16 by 58 * SAMPLES through a reciprocal that is exact for all sums.
  localparam int DIV     = uera_pkg::EchoUsPerCm * SAMPLES;
  localparam int DIV_LOG = $clog2(DIV);
  localparam int SHIFT   = SUM_W + uera_pkg::QFrac + DIV_LOG;
  localparam int MUL_W   = SHIFT - DIV_LOG + 2;
  localparam int PROD_W  = SUM_W + MUL_W;
  localparam int QUOT_W  = PROD_W - (SHIFT - uera_pkg::QFrac);
  localparam logic [63:0] MUL_K64 = ((64'd1 << SHIFT) + 64'(DIV) - 64'd1) / 64'(DIV);
  localparam logic [MUL_W-1:0] MUL_K = MUL_K64[MUL_W-1:0];
  localparam logic [CNT_W-1:0] ECHO_MAX =
    CNT_W'((64'd1 << ECHO_WIDTH_BITS) - 64'd1);

  uera_pkg::phase_t          phase, phase_next;
  logic [CNT_W-1:0]          tick_count, tick_count_next;
  logic [RND_W-1:0]          round_index, round_index_next;
  logic [SUM_W-1:0]          width_sum, width_sum_next;
  logic [uera_pkg::DIST_W-1:0] last_distance, last_distance_next;
  logic [PROD_W-1:0]         avg_prod;
  logic [QUOT_W-1:0]         avg_quot;
  logic [uera_pkg::DIST_W-1:0] avg_q4;
  logic                      trig, done;

  // Reciprocal product of the stored sum, so it always matches the current sum,
  // even when the last round ends on the tick right before the final gap tick.
  assign avg_prod = PROD_W'(width_sum) * PROD_W'(MUL_K);

  // Quotient and saturation to 15 bits.
  assign avg_quot = avg_prod[PROD_W-1:SHIFT-uera_pkg::QFrac];
  assign avg_q4   = (32'(avg_quot) > 32'(uera_pkg::DIST_MAX)) ? uera_pkg::DIST_MAX
                                                            : uera_pkg::DIST_W'(avg_quot);

  // Next state for one tick: entries into the trigger phase first, then the phase work.
  always_comb begin
    phase_next         = phase;
    tick_count_next    = tick_count;
    round_index_next   = round_index;
    width_sum_next     = width_sum;
    last_distance_next = last_distance;
    trig               = 1'b0;
    done               = 1'b0;

    unique case (phase)
      uera_pkg::PH_IDLE: begin
        if (start_req) begin
          width_sum_next   = '0;
          round_index_next = '0;
          tick_count_next  = '0;
          phase_next       = uera_pkg::PH_TRIG;
        end
      end
      uera_pkg::PH_GAP: begin
        if (tick_count < CNT_W'(cfg.gap_us)) begin
          tick_count_next = tick_count + CNT_W'(1);
        end else if (round_index >= RND_W'(SAMPLES)) begin
          last_distance_next = avg_q4;
          done               = 1'b1;
          tick_count_next    = '0;
          phase_next         = uera_pkg::PH_IDLE;
        end else begin
          tick_count_next = '0;
          phase_next      = uera_pkg::PH_TRIG;
        end
      end
      default: begin
      end
    endcase

    unique case (phase_next)
      uera_pkg::PH_TRIG: begin
        trig            = 1'b1;
        tick_count_next = tick_count_next + CNT_W'(1);
        if (tick_count_next >= CNT_W'(cfg.trigger_len_us)) begin
          tick_count_next = '0;
          phase_next      = uera_pkg::PH_WAIT;
        end
      end
      uera_pkg::PH_WAIT: begin
        if (echo_level) begin
          tick_count_next = CNT_W'(1);
          phase_next      = uera_pkg::PH_MEAS;
        end
      end
      uera_pkg::PH_MEAS: begin
        if (echo_level) begin
          if (tick_count_next < ECHO_MAX) begin
            tick_count_next = tick_count_next + CNT_W'(1);
          end
        end else begin
          width_sum_next   = width_sum + SUM_W'(tick_count_next);
          round_index_next = round_index + RND_W'(1);
          tick_count_next  = '0;
          phase_next       = uera_pkg::PH_GAP;
        end
      end
      default: begin
      end
    endcase

    res.trigger_level = trig;
    res.busy_res      = (phase_next != uera_pkg::PH_IDLE);
    res.done_res      = done;
    res.distance_q4   = last_distance_next;
  end

  // State registers advance once per processed tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= uera_pkg::PH_IDLE;
      tick_count    <= '0;
      round_index   <= '0;
      width_sum     <= '0;
      last_distance <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_count    <= tick_count_next;
      round_index   <= round_index_next;
      width_sum     <= width_sum_next;
      last_distance <= last_distance_next;
    end
  end

  // The round counter never runs past the sample count.
  a_round_bound: assert property (@(posedge clk) disable iff (rst)
    round_index <= RND_W'(SAMPLES))
    else $error("round index past sample count");

  // A finished measurement always returns to idle.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    step && res.done_res |=> phase == uera_pkg::PH_IDLE)
    else $error("done without return to idle");

  // The trigger is only driven while a sequence is running.
  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    step && res.trigger_level |-> res.busy_res && !res.done_res)
    else $error("trigger outside a running sequence");

  // Without a processed tick the sequencer state holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(tick_count) && $stable(width_sum))
    else $error("sequencer state moved without a tick");

endmodule

@@ hw/rtl/ultrasonic_echo_ranger_avg_top.sv @@
// Top level of the averaging ultrasonic echo ranger: tick pipeline and register port.
// A request passes the request register and then the result register; a stall can hold it in between.
// Throughput: one request per cycle while the result register is free; the sequencer updates once per tick.
// One measurement spans SAMPLES rounds of trigger, echo wait, echo count and gap ticks.
// Reset: sequencer idle, counters and distance zero, trigger length 20, gap 10000.
// Reset empties the request and result registers; no clearing pass is needed.
module ultrasonic_echo_ranger_avg_top #(
  parameter int SAMPLES         = uera_pkg::SAMPLES_DEF,
  parameter int ECHO_WIDTH_BITS = uera_pkg::ECHO_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  uera_in_if.sink                       item,
  uera_out_if.source                    result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [uera_pkg::ADDR_W-1:0]   paddr,
  input  logic [uera_pkg::DATA_W-1:0]   pwdata,
  output logic [uera_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  uera_pkg::cfg_t cfg;
  uera_pkg::res_t res;
  uera_pkg::res_t res_reg;
  logic           s1_valid;
  logic           s1_start;
  logic           s1_echo;
  logic           out_valid;
  logic           advance;
  logic           step;

  uera_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  uera_core #(
    .SAMPLES         (SAMPLES),
    .ECHO_WIDTH_BITS (ECHO_WIDTH_BITS)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .start_req  (s1_start),
    .echo_level (s1_echo),
    .cfg        (cfg),
    .res        (res)
  );

  // Pipeline control: the result register frees up when taken or empty.
  assign advance    = !out_valid || result.ready;
  assign step       = s1_valid && advance;
  assign item.ready = !s1_valid || advance;

  // Request register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_start <= item.start_req;
      s1_echo  <= item.echo_level;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_reg <= res;
    end
  end

  assign result.valid         = out_valid;
  assign result.trigger_level = res_reg.trigger_level;
  assign result.busy_res      = res_reg.busy_res;
  assign result.done_res      = res_reg.done_res;
  assign result.distance_q4   = res_reg.distance_q4;

endmodule
